// File: sv/btspa_pkg.sv
// ---------------------------------------------------------------------------
// btspa_pkg
// Types and fixed constants of the boundary-tag stack pool allocator.
// ---------------------------------------------------------------------------
package btspa_pkg;

    localparam int unsigned CFG_W      = 15;
    localparam int unsigned TAG_W      = 15;
    // rounded request size, up to 32768 bytes
    localparam int unsigned SZ_W       = 16;
    localparam int unsigned POOL_SHIFT = 24;
    localparam int unsigned TAG_BYTES  = 4;

    localparam logic [CFG_W-1:0] POOL_BYTES_RST = 15'd16384;
    localparam logic [31:0]      NO_HANDLE      = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_RESET = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_BAD_HANDLE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_PLACE,
        S_A_TRAIL,
        S_F_RD,
        S_F_CHK,
        S_W_RT,
        S_W_CT,
        S_W_RP,
        S_W_CP,
        S_W_END,
        S_EMIT
    } state_t;

endpackage

// File: sv/btspa_req_if.sv
// ---------------------------------------------------------------------------
// btspa_req_if
// Request channel: action, size and handle with valid/ready.
// ---------------------------------------------------------------------------
interface btspa_req_if;

    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [14:0] size_bytes;
    logic [31:0] handle;

    modport source (output valid, output action, output size_bytes, output handle,
                    input ready);
    modport sink   (input valid, input action, input size_bytes, input handle,
                    output ready);

endinterface

// File: sv/btspa_rsp_if.sv
// ---------------------------------------------------------------------------
// btspa_rsp_if
// Response channel: result handle and status with valid/ready.
// ---------------------------------------------------------------------------
interface btspa_rsp_if;

    logic        valid;
    logic        ready;
    logic [31:0] result_handle;
    logic [1:0]  status;

    modport source (output valid, output result_handle, output status, input ready);
    modport sink   (input valid, input result_handle, input status, output ready);

endinterface

// File: sv/boundary_tag_stack_pool_allocator.sv
// ---------------------------------------------------------------------------
// boundary_tag_stack_pool_allocator
// Bump-stack pool allocator with head and trail size tags in a tag memory.
// ---------------------------------------------------------------------------
// Usage: requests enter on req (allocate, free, reset all pools); every request
// gives exactly one word on rsp with a result handle and a status. pool_bytes is
// written through cfg_wr_en / cfg_wr_data while the block is idle.
// One request is worked on at a time; req.ready is high only between requests.
// Steps per request: reset-all, unknown action, empty/bad handle and oversized
// alloc go straight to the output register. alloc reads the top of each active
// pool in turn and writes the head tag, then the trail tag, in the first that
// fits, else opens a fresh pool (no pool_top read); no room anywhere once all
// pools are active gives no-space. free reads the head tag and the top and clears
// the head tag; freeing the top block walks the top back over freed blocks below.
// The tag memory and pool_top memory are single-port; a new request waits for the last.
// The result sits in an output register: while rsp is stalled the next request
// is already accepted and worked on, and only its result waits.
// Reset empties every pool (valid bits of pool_top cleared), deactivates all
// pools and sets pool_bytes to 16384; the tag memory is not cleared.
// ---------------------------------------------------------------------------
module boundary_tag_stack_pool_allocator #(
    parameter int unsigned NUM_POOLS  = 8,
    parameter int unsigned POOL_WORDS = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [btspa_pkg::CFG_W-1:0] cfg_wr_data,
    btspa_req_if.sink                 req,
    btspa_rsp_if.source               rsp
);

    localparam int unsigned BYTE_W  = $clog2(POOL_WORDS * 4 + 1);
    localparam int unsigned CALC_W  = ((BYTE_W > btspa_pkg::SZ_W) ? BYTE_W
                                                                  : btspa_pkg::SZ_W) + 1;
    localparam int unsigned ACT_W   = $clog2(NUM_POOLS + 1);
    localparam int unsigned POOL_IW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int unsigned TAG_DEPTH = NUM_POOLS * POOL_WORDS;
    localparam int unsigned TAG_AW  = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
    localparam logic [CALC_W-1:0] CAP    = CALC_W'(POOL_WORDS * 4);
    localparam logic [CALC_W-1:0] TAG4   = CALC_W'(btspa_pkg::TAG_BYTES);
    localparam logic [CALC_W-1:0] TAG8   = CALC_W'(2 * btspa_pkg::TAG_BYTES);

    // memories
    logic [btspa_pkg::TAG_W-1:0] tag_mem [TAG_DEPTH];
    logic [BYTE_W-1:0]           top_mem [NUM_POOLS];

    btspa_pkg::state_t state_reg, state_next;
    logic [ACT_W-1:0]            active_reg, active_next;
    logic [NUM_POOLS-1:0]        top_vld_reg, top_vld_next;
    logic                        out_valid_reg, out_valid_next;
    logic [btspa_pkg::CFG_W-1:0] pool_bytes_reg;

    logic [btspa_pkg::SZ_W-1:0]  size_reg, size_next;
    logic [BYTE_W-1:0]           cur_reg, cur_next;
    logic [BYTE_W-1:0]           prev_reg, prev_next;
    logic [ACT_W-1:0]            pool_idx_reg, pool_idx_next;
    logic [31:0]                 res_handle_reg, res_handle_next;
    logic [1:0]                  res_status_reg, res_status_next;
    logic [31:0]                 out_handle_reg, out_handle_next;
    logic [1:0]                  out_status_reg, out_status_next;

    logic [btspa_pkg::TAG_W-1:0] tag_rd_reg;
    logic [BYTE_W-1:0]           top_rd_reg;

    logic                        tag_re, tag_we;
    logic [BYTE_W-1:0]           tag_off;
    logic [btspa_pkg::TAG_W-1:0] tag_wdata;
    logic [TAG_AW-1:0]           tag_addr;
    logic                        top_re, top_we;
    logic [BYTE_W-1:0]           top_wdata;

    logic [CALC_W-1:0]           usable;
    logic [CALC_W-1:0]           pb_masked;
    logic [CALC_W-1:0]           req_size;
    logic [7:0]                  req_pool;
    logic [23:0]                 req_off;
    logic [23:0]                 req_head;
    logic                        req_bad;
    logic [BYTE_W-1:0]           top_val;
    logic [CALC_W-1:0]           cur_w;
    logic [CALC_W-1:0]           size_w;
    logic [CALC_W-1:0]           tag_rd_w;
    logic                        fits;
    logic [POOL_IW-1:0]          pidx;

    assign pidx      = pool_idx_reg[POOL_IW-1:0];
    assign pb_masked = CALC_W'({pool_bytes_reg[btspa_pkg::CFG_W-1:2], 2'b00});
    assign usable    = (pb_masked > CAP) ? CAP : pb_masked;

    assign req_size  = (CALC_W'(req.size_bytes) + CALC_W'(3)) & ~CALC_W'(3);
    assign req_pool  = req.handle[31:btspa_pkg::POOL_SHIFT];
    assign req_off   = req.handle[btspa_pkg::POOL_SHIFT-1:0];
    assign req_head  = req_off - 24'(btspa_pkg::TAG_BYTES);
    assign req_bad   = (req_pool >= 8'(active_reg))
                    || (req_off < 24'(btspa_pkg::TAG_BYTES))
                    || (req_off[1:0] != 2'b00)
                    || (req_head >= 24'(usable));

    assign top_val  = top_vld_reg[pidx] ? top_rd_reg : '0;
    assign cur_w    = CALC_W'(cur_reg);
    assign size_w   = CALC_W'(size_reg);
    assign tag_rd_w = CALC_W'(tag_rd_reg);
    assign fits     = (CALC_W'(top_val) <= usable)
                   && ((usable - CALC_W'(top_val)) >= (size_w + TAG8));

    // pool base plus word index of the tag
    assign tag_addr = TAG_AW'(pool_idx_reg) * TAG_AW'(POOL_WORDS)
                    + TAG_AW'(tag_off[BYTE_W-1:2]);

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        top_vld_next    = top_vld_reg;
        out_valid_next  = out_valid_reg;
        size_next       = size_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        pool_idx_next   = pool_idx_reg;
        res_handle_next = res_handle_reg;
        res_status_next = res_status_reg;
        out_handle_next = out_handle_reg;
        out_status_next = out_status_reg;
        tag_re          = 1'b0;
        tag_we          = 1'b0;
        tag_off         = cur_reg;
        tag_wdata       = '0;
        top_re          = 1'b0;
        top_we          = 1'b0;
        top_wdata       = cur_reg;
        req.ready       = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            btspa_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    res_handle_next = btspa_pkg::NO_HANDLE;
                    res_status_next = btspa_pkg::ST_OK;
                    size_next       = req_size[btspa_pkg::SZ_W-1:0];
                    state_next      = btspa_pkg::S_EMIT;
                    case (req.action)
                        btspa_pkg::ACT_ALLOC:
                        begin
                            if (req_size + TAG8 > usable)
                            begin
                                res_status_next = btspa_pkg::ST_NO_SPACE;
                            end
                            else if (active_reg == '0)
                            begin
                                pool_idx_next = '0;
                                cur_next      = '0;
                                state_next    = btspa_pkg::S_A_PLACE;
                            end
                            else
                            begin
                                pool_idx_next = '0;
                                state_next    = btspa_pkg::S_A_RD;
                            end
                        end
                        btspa_pkg::ACT_FREE:
                        begin
                            if (req.handle == btspa_pkg::NO_HANDLE)
                            begin
                                res_status_next = btspa_pkg::ST_OK;
                            end
                            else if (req_bad)
                            begin
                                res_status_next = btspa_pkg::ST_BAD_HANDLE;
                            end
                            else
                            begin
                                pool_idx_next = req_pool[ACT_W-1:0];
                                cur_next      = req_head[BYTE_W-1:0];
                                state_next    = btspa_pkg::S_F_RD;
                            end
                        end
                        btspa_pkg::ACT_RESET:
                        begin
                            top_vld_next = '0;
                        end
                        default:
                        begin
                            res_status_next = btspa_pkg::ST_OK;
                        end
                    endcase
                end
            end

            btspa_pkg::S_A_RD:
            begin
                top_re     = 1'b1;
                state_next = btspa_pkg::S_A_CHK;
            end

            btspa_pkg::S_A_CHK:
            begin
                if (fits)
                begin
                    cur_next   = top_val;
                    state_next = btspa_pkg::S_A_PLACE;
                end
                else if (pool_idx_reg + ACT_W'(1) < active_reg)
                begin
                    pool_idx_next = pool_idx_reg + ACT_W'(1);
                    state_next    = btspa_pkg::S_A_RD;
                end
                else if (active_reg == ACT_W'(NUM_POOLS))
                begin
                    res_status_next = btspa_pkg::ST_NO_SPACE;
                    state_next      = btspa_pkg::S_EMIT;
                end
                else
                begin
                    // open the next pool, empty
                    pool_idx_next = active_reg;
                    cur_next      = '0;
                    state_next    = btspa_pkg::S_A_PLACE;
                end
            end

            btspa_pkg::S_A_PLACE:
            begin
                tag_we             = 1'b1;
                tag_off            = cur_reg;
                tag_wdata          = size_reg[btspa_pkg::TAG_W-1:0];
                top_we             = 1'b1;
                top_wdata          = BYTE_W'(cur_w + size_w + TAG8);
                top_vld_next[pidx] = 1'b1;
                if (pool_idx_reg == active_reg)
                begin
                    active_next = active_reg + ACT_W'(1);
                end
                res_handle_next = {8'(pool_idx_reg), 24'(cur_w + TAG4)};
                res_status_next = btspa_pkg::ST_OK;
                state_next      = btspa_pkg::S_A_TRAIL;
            end

            btspa_pkg::S_A_TRAIL:
            begin
                tag_we     = 1'b1;
                tag_off    = BYTE_W'(cur_w + TAG4 + size_w);
                tag_wdata  = size_reg[btspa_pkg::TAG_W-1:0];
                state_next = btspa_pkg::S_EMIT;
            end

            btspa_pkg::S_F_RD:
            begin
                tag_re     = 1'b1;
                top_re     = 1'b1;
                state_next = btspa_pkg::S_F_CHK;
            end

            btspa_pkg::S_F_CHK:
            begin
                // clear head tag; walk back only if this was the top block
                tag_we    = 1'b1;
                tag_wdata = '0;
                if (cur_w + tag_rd_w + TAG8 == CALC_W'(top_val))
                begin
                    state_next = btspa_pkg::S_W_RT;
                end
                else
                begin
                    state_next = btspa_pkg::S_EMIT;
                end
            end

            btspa_pkg::S_W_RT:
            begin
                if (cur_reg == '0)
                begin
                    state_next = btspa_pkg::S_W_END;
                end
                else
                begin
                    tag_re     = 1'b1;
                    tag_off    = BYTE_W'(cur_w - TAG4);
                    state_next = btspa_pkg::S_W_CT;
                end
            end

            btspa_pkg::S_W_CT:
            begin
                // trail tag pointing below the pool start ends the walk
                if (tag_rd_w + TAG8 > cur_w)
                begin
                    state_next = btspa_pkg::S_W_END;
                end
                else
                begin
                    prev_next  = BYTE_W'(cur_w - tag_rd_w - TAG8);
                    state_next = btspa_pkg::S_W_RP;
                end
            end

            btspa_pkg::S_W_RP:
            begin
                tag_re     = 1'b1;
                tag_off    = prev_reg;
                state_next = btspa_pkg::S_W_CP;
            end

            btspa_pkg::S_W_CP:
            begin
                if (tag_rd_reg != '0)
                begin
                    state_next = btspa_pkg::S_W_END;
                end
                else
                begin
                    cur_next   = prev_reg;
                    state_next = btspa_pkg::S_W_RT;
                end
            end

            btspa_pkg::S_W_END:
            begin
                top_we             = 1'b1;
                top_wdata          = cur_reg;
                top_vld_next[pidx] = 1'b1;
                state_next         = btspa_pkg::S_EMIT;
            end

            btspa_pkg::S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_handle_next = res_handle_reg;
                    out_status_next = res_status_reg;
                    state_next      = btspa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = btspa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= btspa_pkg::S_IDLE;
            active_reg     <= '0;
            top_vld_reg    <= '0;
            out_valid_reg  <= 1'b0;
            pool_bytes_reg <= btspa_pkg::POOL_BYTES_RST;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            top_vld_reg   <= top_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                pool_bytes_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        pool_idx_reg   <= pool_idx_next;
        res_handle_reg <= res_handle_next;
        res_status_reg <= res_status_next;
        out_handle_reg <= out_handle_next;
        out_status_reg <= out_status_next;
    end

    // tag memory, one access per cycle
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_addr] <= tag_wdata;
        end
        if (tag_re)
        begin
            tag_rd_reg <= tag_mem[tag_addr];
        end
    end

    // pool top memory
    always_ff @(posedge clk)
    begin
        if (top_we)
        begin
            top_mem[pidx] <= top_wdata;
        end
        if (top_re)
        begin
            top_rd_reg <= top_mem[pidx];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.result_handle = out_handle_reg;
    assign rsp.status        = out_status_reg;

endmodule

// File: sv/btspa_checker.sv
// ---------------------------------------------------------------------------
// btspa_checker
// Port-level checks of the pool allocator, bound to the top level.
// ---------------------------------------------------------------------------
module btspa_checker #(
    parameter int unsigned NUM_POOLS = 8
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_result_handle,
    input logic [1:0]  rsp_status
);

    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    // failures never carry a handle
    a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != btspa_pkg::ST_OK |->
        rsp_result_handle == btspa_pkg::NO_HANDLE)
        else $error("failed word carries a handle");

    // a real handle names an existing pool and a word-aligned payload offset
    a_handle_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_result_handle != btspa_pkg::NO_HANDLE |->
        rsp_result_handle[31:24] < 8'(NUM_POOLS) && rsp_result_handle[1:0] == 2'b00
        && rsp_result_handle[23:0] != 24'd0)
        else $error("malformed handle");

    // stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
        rsp_valid && $stable(rsp_result_handle) && $stable(rsp_status))
        else $error("stalled response word changed");

endmodule

bind boundary_tag_stack_pool_allocator btspa_checker #(
    .NUM_POOLS (NUM_POOLS)
) u_btspa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_result_handle (rsp.result_handle),
    .rsp_status        (rsp.status)
);

// File: test/boundary_tag_stack_pool_allocator_test.sv
// ---------------------------------------------------------------------------
// boundary_tag_stack_pool_allocator_test
// Self-checking bench for the pool allocator. Requests (allocate, free, reset
// all pools, unknown) go in over the request channel with random gaps, while the
// response side stalls at random. A model of the pools, their tags and tops
// predicts each response word, and the words are compared field by field in
// order. The run goes through several pool_bytes settings, each written while
// the block is idle.
// ---------------------------------------------------------------------------

typedef struct packed {
    logic [31:0]        handle;
    btspa_pkg::status_t status;
} alloc_rsp_t;

class pool_alloc_scoreboard #(int unsigned POOLS = 8, int unsigned WORDS = 4096);

    localparam logic [31:0] POOL_FIELD   = 32'hFF00_0000;
    localparam logic [31:0] OFFSET_FIELD = 32'h00FF_FFFF;

    bit [btspa_pkg::TAG_W-1:0]   tags [POOLS][WORDS];
    bit                          tag_known [POOLS][WORDS];
    int unsigned                 pool_top [POOLS];
    int unsigned                 pools_active;
    logic [btspa_pkg::CFG_W-1:0] pool_bytes;
    alloc_rsp_t                  expected_rsp [$];
    logic [31:0]                 live_handles [$];
    logic [31:0]                 stale_handles [$];
    int                          errors;

    // trial free: the cleared head reads as zero, nothing is written
    bit               dry;
    int unsigned      dry_pool;
    int unsigned      dry_head;
    bit               saw_unknown;

    function new();
        pools_active = 0;
        pool_bytes = btspa_pkg::POOL_BYTES_RST;
        errors = 0;
        foreach (pool_top[i]) pool_top[i] = 0;
    endfunction

    function int unsigned usable_bytes();
        int unsigned pb;
        pb = {17'd0, pool_bytes} & 32'h0000_7FFC;
        return (pb > WORDS * btspa_pkg::TAG_BYTES) ? WORDS * btspa_pkg::TAG_BYTES : pb;
    endfunction

    function bit [btspa_pkg::TAG_W-1:0] read_tag(int unsigned p, int unsigned off);
        int unsigned w;
        w = off >> 2;
        if (p >= POOLS || w >= WORDS) return '0;
        if (dry && p == dry_pool && off == dry_head) return '0;
        if (!tag_known[p][w]) saw_unknown = 1'b1;
        return tags[p][w];
    endfunction

    function void write_tag(int unsigned p, int unsigned off,
                            bit [btspa_pkg::TAG_W-1:0] v);
        int unsigned w;
        w = off >> 2;
        if (p >= POOLS || w >= WORDS) return;
        tags[p][w] = v;
        tag_known[p][w] = 1'b1;
    endfunction

    function bit place_block(int unsigned p, int unsigned sz, int unsigned pb,
                             output logic [31:0] h);
        int unsigned t;
        t = pool_top[p];
        h = btspa_pkg::NO_HANDLE;
        if (t > pb || pb - t < sz + 2 * btspa_pkg::TAG_BYTES) return 1'b0;
        write_tag(p, t, sz[btspa_pkg::TAG_W-1:0]);
        write_tag(p, t + btspa_pkg::TAG_BYTES + sz, sz[btspa_pkg::TAG_W-1:0]);
        pool_top[p] = t + sz + 2 * btspa_pkg::TAG_BYTES;
        h = ((p << btspa_pkg::POOL_SHIFT) & POOL_FIELD)
          | ((t + btspa_pkg::TAG_BYTES) & OFFSET_FIELD);
        return 1'b1;
    endfunction

    function btspa_pkg::status_t alloc_block(logic [btspa_pkg::CFG_W-1:0] raw,
                                             output logic [31:0] h);
        int unsigned sz;
        int unsigned pb;
        int unsigned i;
        sz = ({17'd0, raw} + 32'd3) & ~32'd3;
        pb = usable_bytes();
        h = btspa_pkg::NO_HANDLE;
        if (sz + 2 * btspa_pkg::TAG_BYTES > pb) return btspa_pkg::ST_NO_SPACE;
        for (i = 0; i < pools_active && i < POOLS; i++)
            if (place_block(i, sz, pb, h)) return btspa_pkg::ST_OK;
        if (pools_active >= POOLS) return btspa_pkg::ST_NO_SPACE;
        pool_top[pools_active] = 0;
        if (!place_block(pools_active, sz, pb, h)) return btspa_pkg::ST_NO_SPACE;
        pools_active++;
        return btspa_pkg::ST_OK;
    endfunction

    function btspa_pkg::status_t free_block(logic [31:0] h, bit commit);
        int unsigned p;
        int unsigned off;
        int unsigned head;
        int unsigned sz;
        int unsigned t;
        int unsigned trail;
        int unsigned prev;
        dry = !commit;
        dry_pool = POOLS;
        saw_unknown = 1'b0;
        if (h == btspa_pkg::NO_HANDLE) return btspa_pkg::ST_OK;
        p = h >> btspa_pkg::POOL_SHIFT;
        off = h & OFFSET_FIELD;
        if (p >= pools_active || p >= POOLS) return btspa_pkg::ST_BAD_HANDLE;
        if (off < btspa_pkg::TAG_BYTES || off % btspa_pkg::TAG_BYTES != 0)
            return btspa_pkg::ST_BAD_HANDLE;
        head = off - btspa_pkg::TAG_BYTES;
        if (head >= usable_bytes()) return btspa_pkg::ST_BAD_HANDLE;
        sz = 32'(read_tag(p, head));
        if (commit)
        begin
            write_tag(p, head, '0);
        end
        else
        begin
            dry_pool = p;
            dry_head = head;
        end
        if (head + sz + 2 * btspa_pkg::TAG_BYTES == pool_top[p])
        begin
            // top block freed: pull the top back over freed blocks below it
            t = head;
            while (t > 0)
            begin
                trail = 32'(read_tag(p, t - btspa_pkg::TAG_BYTES));
                if (trail + 2 * btspa_pkg::TAG_BYTES > t) break;
                prev = t - trail - 2 * btspa_pkg::TAG_BYTES;
                if (read_tag(p, prev) != 0) break;
                t = prev;
            end
            if (commit) pool_top[p] = t;
        end
        return btspa_pkg::ST_OK;
    endfunction

    // true when freeing h reads only tag entries written since reset
    function bit frees_cleanly(logic [31:0] h);
        void'(free_block(h, 1'b0));
        return !saw_unknown;
    endfunction

    function void retire(logic [31:0] h);
        stale_handles.push_back(h);
        if (stale_handles.size() > 64) void'(stale_handles.pop_front());
    endfunction

    function void note_request(logic [1:0] act, logic [btspa_pkg::CFG_W-1:0] sz,
                               logic [31:0] h);
        alloc_rsp_t  e;
        logic [31:0] got;
        int          i;
        e.handle = btspa_pkg::NO_HANDLE;
        e.status = btspa_pkg::ST_OK;
        if (act == btspa_pkg::ACT_ALLOC)
        begin
            e.status = alloc_block(sz, got);
            if (e.status == btspa_pkg::ST_OK)
            begin
                e.handle = got;
                live_handles.push_back(got);
            end
        end
        else if (act == btspa_pkg::ACT_FREE)
        begin
            e.status = free_block(h, 1'b1);
            for (i = 0; i < live_handles.size(); i++)
            begin
                if (live_handles[i] == h)
                begin
                    live_handles.delete(i);
                    break;
                end
            end
            if (e.status == btspa_pkg::ST_OK && h != btspa_pkg::NO_HANDLE) retire(h);
        end
        else if (act == btspa_pkg::ACT_RESET)
        begin
            foreach (pool_top[j]) pool_top[j] = 0;
            while (live_handles.size() != 0) retire(live_handles.pop_front());
        end
        expected_rsp.push_back(e);
    endfunction

    function void check_result(logic [31:0] h, logic [1:0] st);
        alloc_rsp_t e;
        if (expected_rsp.size() == 0)
        begin
            $display("%0t: response word with none expected, handle %h status %0d",
                     $time, h, st);
            errors++;
            return;
        end
        e = expected_rsp.pop_front();
        if (h !== e.handle)
        begin
            $display("%0t: result_handle expected %h actual %h", $time, e.handle, h);
            errors++;
        end
        if (st !== e.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
        end
    endfunction

endclass

module boundary_tag_stack_pool_allocator_test;

    localparam int unsigned NUM_POOLS       = 8;
    localparam int unsigned POOL_WORDS      = 4096;
    localparam logic [1:0]  ACT_UNKNOWN     = 2'd3;
    localparam int          PHASES          = 7;
    localparam int          ITEMS_PER_PHASE = 64;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [btspa_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic                        rsp_ready_q = 1'b0;
    int                          rsp_stall = 0;
    bit                          req_quiet = 1'b0;
    bit                          rsp_quiet = 1'b0;
    int unsigned                 cycles = 0;

    pool_alloc_scoreboard #(NUM_POOLS, POOL_WORDS) pool_model;

    btspa_req_if req ();
    btspa_rsp_if rsp ();

    assign rsp.ready = rsp_ready_q;

    boundary_tag_stack_pool_allocator #(
        .NUM_POOLS  (NUM_POOLS),
        .POOL_WORDS (POOL_WORDS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp         (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int pick_gap(bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // response side: check the accepted word, then pick the next ready
    always @(posedge clk)
    begin
        if (rsp.valid === 1'b1 && rsp_ready_q)
            pool_model.check_result(rsp.result_handle, rsp.status);
        if (rsp_stall != 0)
        begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready_q <= 1'b0;
        end
        else
        begin
            rsp_ready_q <= 1'b1;
            rsp_stall <= pick_gap(rsp_quiet);
        end
    end

    task automatic issue(input logic [1:0] act, input logic [btspa_pkg::CFG_W-1:0] sz,
                         input logic [31:0] h);
        int n;
        req.valid <= 1'b1;
        req.action <= act;
        req.size_bytes <= sz;
        req.handle <= h;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        pool_model.note_request(act, sz, h);
        n = pick_gap(req_quiet);
        if (n != 0)
        begin
            req.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (pool_model.expected_rsp.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_pool_bytes(input logic [btspa_pkg::CFG_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pool_model.pool_bytes = v;
    endtask

    task automatic run_directed();
        int i;
        issue(btspa_pkg::ACT_FREE, '0, btspa_pkg::NO_HANDLE);
        issue(btspa_pkg::ACT_FREE, '0, 32'h0);            // no pool active yet
        issue(btspa_pkg::ACT_ALLOC, '0, 32'h0);           // zero-size block
        issue(btspa_pkg::ACT_ALLOC, 15'd5, 32'h0);        // rounds up to 8
        issue(btspa_pkg::ACT_ALLOC, 15'h7FFF, 32'h0);     // larger than any pool
        issue(btspa_pkg::ACT_ALLOC, 15'd16376, 32'h0);    // fills a fresh pool
        issue(btspa_pkg::ACT_FREE, '0, 32'd14);           // misaligned offset
        issue(btspa_pkg::ACT_FREE, '0, 32'd0);            // offset below head tag
        issue(btspa_pkg::ACT_FREE, '0, (32'd5 << btspa_pkg::POOL_SHIFT) | 32'd4);
        issue(btspa_pkg::ACT_FREE, '0, 32'd16388);        // head past pool end
        issue(btspa_pkg::ACT_FREE, '0, 32'hFF00_0004);
        issue(btspa_pkg::ACT_FREE, '0, 32'd12);           // top walks over zero-size
        issue(ACT_UNKNOWN, 15'h7FFF, btspa_pkg::NO_HANDLE);
        issue(btspa_pkg::ACT_RESET, '0, 32'h0);
        issue(btspa_pkg::ACT_ALLOC, 15'd4, 32'h0);
        issue(btspa_pkg::ACT_ALLOC, 15'd200, 32'h0);
        issue(btspa_pkg::ACT_FREE, '0, 32'd4);            // not the top block
        issue(btspa_pkg::ACT_FREE, '0, 32'd16);           // top walks over freed one
        issue(btspa_pkg::ACT_ALLOC, 15'd200, 32'h0);
        // tiny pools: pool 0 now lies past the end, the rest fill one by one
        wait_idle();
        write_pool_bytes(15'd16);
        for (i = 0; i < 8; i++) issue(btspa_pkg::ACT_ALLOC, 15'd8, 32'h0);
        issue(btspa_pkg::ACT_FREE, '0, pool_model.live_handles[$]);
    endtask

    task automatic send_random();
        int unsigned                 r;
        int unsigned                 k;
        int unsigned                 lim;
        int unsigned                 nlive;
        logic [1:0]                  act;
        logic [btspa_pkg::CFG_W-1:0] sz;
        logic [31:0]                 h;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 9);
        sz = 15'($urandom_range(0, 32767));
        h = $urandom;
        lim = pool_model.usable_bytes();
        nlive = pool_model.live_handles.size();
        if (r < 55)
        begin
            act = btspa_pkg::ACT_ALLOC;
            if (k == 0)
                sz = '0;
            else if (k == 1)
                sz = 15'(lim - 8 - $urandom_range(0, 3));
            else if (k != 2)
                sz = 15'($urandom_range(0, lim / 4));
        end
        else if (r < 88)
        begin
            act = btspa_pkg::ACT_FREE;
            if (k < 4 && nlive != 0)
                h = pool_model.live_handles[nlive - 1];
            else if (k < 7 && nlive != 0)
                h = pool_model.live_handles[$urandom_range(0, nlive - 1)];
            else if (k == 7 && pool_model.stale_handles.size() != 0)
                h = pool_model.stale_handles[
                        $urandom_range(0, pool_model.stale_handles.size() - 1)];
            else if (k == 8)
            begin
                h[31:24] = 8'($urandom_range(0, pool_model.pools_active));
                h[23:0] = 24'($urandom_range(0, lim + 8));
            end
            else if (k == 9)
                h = btspa_pkg::NO_HANDLE;
            // never read a tag entry that was not written: force a bad handle
            if (!pool_model.frees_cleanly(h)) h[0] = 1'b1;
        end
        else if (r < 92)
            act = btspa_pkg::ACT_RESET;
        else if (r < 96)
            act = ACT_UNKNOWN;
        else
        begin
            act = btspa_pkg::ACT_FREE;
            h = btspa_pkg::NO_HANDLE;
        end
        issue(act, sz, h);
    endtask

    initial
    begin
        logic [btspa_pkg::CFG_W-1:0] pb_plan [PHASES];
        int                          ph;
        int                          n;
        pool_model = new();
        pb_plan = '{15'd16384, 15'd16, 15'd32767, 15'd64, 15'd259, 15'd0, 15'd160};
        req.valid <= 1'b0;
        req.action <= btspa_pkg::ACT_ALLOC;
        req.size_bytes <= '0;
        req.handle <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            if (ph == 5)
                write_pool_bytes(15'($urandom_range(4, 300) * 4));
            else
                write_pool_bytes(pb_plan[ph]);
            req_quiet = (ph == 2);
            rsp_quiet = (ph == 3 || ph == 6);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // hold off mid-phase until every response is back
                if (ph == 1 && n == ITEMS_PER_PHASE / 2) wait_idle();
                send_random();
            end
        end

        wait_idle();
        repeat (30) @(posedge clk);
        if (pool_model.errors == 0 && pool_model.expected_rsp.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
sv/btspa_pkg.sv
sv/btspa_req_if.sv
sv/btspa_rsp_if.sv
sv/boundary_tag_stack_pool_allocator.sv
sv/btspa_checker.sv
test/boundary_tag_stack_pool_allocator_test.sv
